// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the machine's RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define TBIS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check on every clock edge, reset included
`define TBIS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== rtl/tbis_pkg.sv =====
// ---------------------------------------------------------------------------
// tbis_pkg
// Types, opcodes, status codes and register indices of the machine.
// ---------------------------------------------------------------------------
package tbis_pkg;

    localparam int MEM_BYTES_DEF = 16384;
    localparam int ADDR_W        = 14;
    localparam int NUM_REGS      = 13;
    localparam int RIDX_W        = 4;
    localparam int CFG_IDX_W     = 2;

    // Register indices
    localparam logic [RIDX_W-1:0] REG_IO = 4'd3;
    localparam logic [RIDX_W-1:0] REG_PC = 4'd8;
    localparam logic [RIDX_W-1:0] REG_SL = 4'd9;
    localparam logic [RIDX_W-1:0] REG_SP = 4'd10;
    localparam logic [RIDX_W-1:0] REG_SB = 4'd12;

    // Configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

    // Opcodes (low five bits of the opcode word)
    localparam logic [4:0] OP_JMP  = 5'd1;
    localparam logic [4:0] OP_JMR  = 5'd2;
    localparam logic [4:0] OP_BNZ  = 5'd3;
    localparam logic [4:0] OP_BGT  = 5'd4;
    localparam logic [4:0] OP_BLT  = 5'd5;
    localparam logic [4:0] OP_BRZ  = 5'd6;
    localparam logic [4:0] OP_MOV  = 5'd7;
    localparam logic [4:0] OP_LDA  = 5'd8;
    localparam logic [4:0] OP_STR  = 5'd9;
    localparam logic [4:0] OP_LDR  = 5'd10;
    localparam logic [4:0] OP_STB  = 5'd11;
    localparam logic [4:0] OP_LDB  = 5'd12;
    localparam logic [4:0] OP_ADD  = 5'd13;
    localparam logic [4:0] OP_ADI  = 5'd14;
    localparam logic [4:0] OP_SUB  = 5'd15;
    localparam logic [4:0] OP_MUL  = 5'd16;
    localparam logic [4:0] OP_DIV  = 5'd17;
    localparam logic [4:0] OP_CMP  = 5'd20;
    localparam logic [4:0] OP_TRP  = 5'd21;
    localparam logic [4:0] OP_ISTR = 5'd22;
    localparam logic [4:0] OP_ILDR = 5'd23;
    localparam logic [4:0] OP_ISTB = 5'd24;
    localparam logic [4:0] OP_ILDB = 5'd25;

    // Trap codes
    localparam logic [31:0] TRAP_HALT    = 32'd0;
    localparam logic [31:0] TRAP_OUT_INT = 32'd1;
    localparam logic [31:0] TRAP_NOP     = 32'd2;
    localparam logic [31:0] TRAP_OUT_CHR = 32'd3;
    localparam logic [31:0] TRAP_IN_CHR  = 32'd4;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BAD_OP = 3'd1;
    localparam logic [2:0] ST_BAD_TRP = 3'd2;
    localparam logic [2:0] ST_BAD_REG = 3'd3;
    localparam logic [2:0] ST_BAD_ADR = 3'd4;
    localparam logic [2:0] ST_DIV0   = 3'd5;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] load_address;
        logic [7:0]        load_byte;
        logic [7:0]        input_char;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pc_after;
        logic               halted;
        logic               out_valid;
        logic               out_is_char;
        logic signed [31:0] out_value;
        logic [2:0]         status;
    } res_t;

    // Opcode is one the machine knows
    function automatic logic op_known(input logic [4:0] op);
        logic ok;
        unique case (op) inside
            OP_JMP, OP_JMR, OP_BNZ, OP_BGT, OP_BLT, OP_BRZ, OP_MOV, OP_LDA,
            OP_STR, OP_LDR, OP_STB, OP_LDB, OP_ADD, OP_ADI, OP_SUB, OP_MUL,
            OP_DIV, OP_CMP, OP_TRP, OP_ISTR, OP_ILDR, OP_ISTB, OP_ILDB: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Second operand names a register
    function automatic logic op_uses_b(input logic [4:0] op);
        logic ub;
        unique case (op) inside
            OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP,
            OP_ISTR, OP_ILDR, OP_ISTB, OP_ILDB: ub = 1'b1;
            default: ub = 1'b0;
        endcase
        return ub;
    endfunction

endpackage

// ===== rtl/tbis_mem.sv =====
// ---------------------------------------------------------------------------
// tbis_mem
// Single-port byte memory with registered read and a clearing sweep
// after reset.
// ---------------------------------------------------------------------------
module tbis_mem #(
    parameter int MEM_BYTES = tbis_pkg::MEM_BYTES_DEF,
    parameter int AW        = $clog2(MEM_BYTES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata,
    output logic          busy
);

    logic [7:0]    mem_arr [MEM_BYTES];
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [7:0]    rdata_reg;

    // Sweep every byte to zero once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(MEM_BYTES - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem_arr[clr_addr_reg] <= 8'd0;
        else if (en && we)
            mem_arr[addr] <= wdata;
        if (en && !we)
            rdata_reg <= mem_arr[addr];
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

// ===== rtl/tbis_regfile.sv =====
// ---------------------------------------------------------------------------
// tbis_regfile
// Thirteen-entry register memory, one write and one registered read port;
// entries not yet written read as their reset value.
// ---------------------------------------------------------------------------
module tbis_regfile #(
    parameter int MEM_BYTES = tbis_pkg::MEM_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [tbis_pkg::RIDX_W-1:0] waddr,
    input  logic [31:0]                 wdata,
    input  logic [tbis_pkg::RIDX_W-1:0] raddr,
    output logic [31:0]                 rdata
);
    import tbis_pkg::*;

    logic [31:0]         rf_arr [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [31:0]         rdata_reg;
    logic                wr_ok;
    logic                rd_ok;

    function automatic logic [31:0] rst_val(input logic [RIDX_W-1:0] idx);
        logic [31:0] v;
        if (idx == REG_SP || idx == REG_SB)
            v = 32'(MEM_BYTES);
        else
            v = 32'd0;
        return v;
    endfunction

    assign wr_ok = we && (waddr < RIDX_W'(NUM_REGS));
    assign rd_ok = (raddr < RIDX_W'(NUM_REGS)) && vld_reg[raddr];

    // Mark entries once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (wr_ok)
            vld_reg[waddr] <= 1'b1;
    end

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_ok)
            rf_arr[waddr] <= wdata;
        rdata_reg <= rd_ok ? rf_arr[raddr] : rst_val(raddr);
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tbis_div.sv =====
// ---------------------------------------------------------------------------
// tbis_div
// Signed 32-bit truncating divider, restoring, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module tbis_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] d_reg;
    logic        neg_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {rem_reg[31:0], q_reg[31]};
    assign diff   = rem_sh - {1'b0, d_reg};

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift and subtract on magnitudes
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[31] ? (32'd0 - dividend) : dividend;
            d_reg   <= divisor[31] ? (32'd0 - divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (32'd0 - q_reg) : q_reg;

endmodule

// ===== rtl/twelve_byte_isa_step.sv =====
// Sequencing: a preload writes its byte when the address is in range; a step is
// paced by twelve one-byte instruction fetches from the single memory port plus
// register reads, and the first step also loads PC and SL from configuration;
// jumps and branches skip write-back, word and byte accesses add memory states,
// and DIV waits on the bit-serial divider. Reset: registers clear at once, then
// the byte memory is swept to zero, during which no request is taken (configuration is).
// ---------------------------------------------------------------------------
// twelve_byte_isa_step
// Multicycle core of a byte-addressed twelve-byte-instruction machine.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twelve_byte_isa_step #(
    parameter int MEM_BYTES = tbis_pkg::MEM_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  tbis_pkg::req_t                 req_data,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tbis_pkg::res_t                 res_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tbis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tbis_pkg::ADDR_W-1:0]    cfg_data
);
    import tbis_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [31:0] FETCH_LIM = 32'(MEM_BYTES - 12);
    localparam logic [31:0] WORD_LIM  = 32'(MEM_BYTES - 4);
    localparam logic [31:0] BYTE_END  = 32'(MEM_BYTES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PRE   = 5'd1;
    localparam logic [4:0] S_START = 5'd2;
    localparam logic [4:0] S_FCHK  = 5'd3;
    localparam logic [4:0] S_FETCH = 5'd4;
    localparam logic [4:0] S_FWAIT = 5'd5;
    localparam logic [4:0] S_DEC   = 5'd6;
    localparam logic [4:0] S_RDX   = 5'd7;
    localparam logic [4:0] S_RDY   = 5'd8;
    localparam logic [4:0] S_RDW   = 5'd9;
    localparam logic [4:0] S_EXEC  = 5'd10;
    localparam logic [4:0] S_MEMW  = 5'd11;
    localparam logic [4:0] S_MEMR  = 5'd12;
    localparam logic [4:0] S_MWAIT = 5'd13;
    localparam logic [4:0] S_DIV   = 5'd14;
    localparam logic [4:0] S_WB    = 5'd15;
    localparam logic [4:0] S_RES   = 5'd16;

    // Control state
    logic [4:0]        state_reg, state_next;
    logic              started_reg, started_next;
    logic              stopped_reg, stopped_next;
    logic              res_valid_reg, res_valid_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [31:0]       pc_reg, pc_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] limit_reg;

    // Datapath
    req_t              req_reg, req_next;
    res_t              res_reg, res_next;
    logic [95:0]       instr_reg, instr_next;
    logic [31:0]       ld_reg, ld_next;
    logic [31:0]       x_reg, x_next;
    logic [31:0]       y_reg, y_next;
    logic [31:0]       wb_val_reg, wb_val_next;
    logic [RIDX_W-1:0] wb_idx_reg, wb_idx_next;
    logic              wb_en_reg, wb_en_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [1:0]        last_reg, last_next;
    logic [31:0]       maddr_reg, maddr_next;
    logic [31:0]       st_reg, st_next;
    logic              sext_reg, sext_next;
    logic              rsel_pc_reg, rsel_pc_next;
    logic [2:0]        status_reg, status_next;
    logic              outv_reg, outv_next;
    logic              outc_reg, outc_next;
    logic [31:0]       outval_reg, outval_next;

    // Memory, register file and divider ports
    logic              mem_en, mem_we, mem_busy;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr, rf_raddr;
    logic [31:0]       rf_wdata, rf_rdata, rf_val;
    logic              div_start, div_busy, div_done;
    logic [31:0]       div_q;

    // Instruction fields
    logic [31:0] op_w, a_w, b_w, maddr_sel;
    logic [4:0]  op5;
    logic        uses_a, uses_b;

    assign op_w   = instr_reg[31:0];
    assign a_w    = instr_reg[63:32];
    assign b_w    = instr_reg[95:64];
    assign op5    = op_w[4:0];
    assign uses_a = (op5 != OP_JMP) && (op5 != OP_TRP);
    assign uses_b = op_uses_b(op5);
    assign rf_val = rsel_pc_reg ? pc_reg : rf_rdata;
    assign maddr_sel = (op5 == OP_STR || op5 == OP_LDR || op5 == OP_STB || op5 == OP_LDB)
                       ? b_w : y_reg;

    tbis_mem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    tbis_regfile #(.MEM_BYTES(MEM_BYTES)) u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    tbis_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign req_ready = (state_reg == S_IDLE) && !mem_busy;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        stopped_next   = stopped_reg;
        res_valid_next = res_valid_reg && !res_ready;
        pc_next        = pc_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        instr_next     = instr_reg;
        ld_next        = ld_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        wb_val_next    = wb_val_reg;
        wb_idx_next    = wb_idx_reg;
        wb_en_next     = wb_en_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        maddr_next     = maddr_reg;
        st_next        = st_reg;
        sext_next      = sext_reg;
        status_next    = status_reg;
        outv_next      = outv_reg;
        outc_next      = outc_reg;
        outval_next    = outval_reg;
        mem_en         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = 8'd0;
        rf_we          = 1'b0;
        rf_waddr       = wb_idx_reg;
        rf_wdata       = wb_val_reg;
        rf_raddr       = '0;
        div_start      = 1'b0;

        // Collect bytes returned by the memory
        if (rd_pend_reg)
        begin
            instr_next = {mem_rdata, instr_reg[95:8]};
            ld_next    = {mem_rdata, ld_reg[31:8]};
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    req_next    = req_data;
                    status_next = ST_OK;
                    outv_next   = 1'b0;
                    outc_next   = 1'b0;
                    outval_next = 32'd0;
                    if (!req_data.operation)
                        state_next = S_PRE;
                    else if (stopped_reg)
                        state_next = S_RES;
                    else if (!started_reg)
                        state_next = S_START;
                    else
                        state_next = S_FCHK;
                end
            end
            S_PRE:
            begin
                if (32'(req_reg.load_address) < BYTE_END)
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = AW'(req_reg.load_address);
                    mem_wdata = req_reg.load_byte;
                end
                state_next = S_RES;
            end
            S_START:
            begin
                pc_next      = 32'(start_reg);
                rf_we        = 1'b1;
                rf_waddr     = REG_SL;
                rf_wdata     = 32'(limit_reg);
                started_next = 1'b1;
                state_next   = S_FCHK;
            end
            S_FCHK:
            begin
                if (pc_reg > FETCH_LIM)
                begin
                    status_next  = ST_BAD_ADR;
                    stopped_next = 1'b1;
                    state_next   = S_RES;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                mem_en   = 1'b1;
                mem_addr = AW'(pc_reg + 32'(cnt_reg));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd11)
                    state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if ((|op_w[31:5]) || !op_known(op5))
                begin
                    status_next  = ST_BAD_OP;
                    stopped_next = 1'b1;
                    state_next   = S_RES;
                end
                else if ((uses_a && a_w >= 32'(NUM_REGS)) ||
                         (uses_b && b_w >= 32'(NUM_REGS)))
                begin
                    status_next  = ST_BAD_REG;
                    stopped_next = 1'b1;
                    state_next   = S_RES;
                end
                else
                    state_next = S_RDX;
            end
            S_RDX:
            begin
                rf_raddr   = (op5 == OP_TRP) ? REG_IO : a_w[RIDX_W-1:0];
                state_next = S_RDY;
            end
            S_RDY:
            begin
                rf_raddr   = b_w[RIDX_W-1:0];
                x_next     = rf_val;
                state_next = S_RDW;
            end
            S_RDW:
            begin
                y_next     = rf_val;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                wb_idx_next = a_w[RIDX_W-1:0];
                wb_en_next  = 1'b1;
                maddr_next  = maddr_sel;
                cnt_next    = '0;
                st_next     = x_reg;
                state_next  = S_WB;
                unique case (op5)
                    OP_JMP:
                    begin
                        pc_next    = a_w;
                        state_next = S_RES;
                    end
                    OP_JMR:
                    begin
                        pc_next    = x_reg;
                        state_next = S_RES;
                    end
                    OP_BNZ, OP_BGT, OP_BLT, OP_BRZ:
                    begin
                        if ((op5 == OP_BNZ && x_reg != 32'd0) ||
                            (op5 == OP_BGT && x_reg != 32'd0 && !x_reg[31]) ||
                            (op5 == OP_BLT && x_reg[31]) ||
                            (op5 == OP_BRZ && x_reg == 32'd0))
                            pc_next = b_w;
                        else
                            pc_next = pc_reg + 32'd12;
                        state_next = S_RES;
                    end
                    OP_MOV: wb_val_next = y_reg;
                    OP_LDA: wb_val_next = b_w;
                    OP_ADD: wb_val_next = x_reg + y_reg;
                    OP_ADI: wb_val_next = x_reg + b_w;
                    OP_SUB: wb_val_next = x_reg - y_reg;
                    OP_MUL: wb_val_next = x_reg * y_reg;
                    OP_CMP:
                    begin
                        if (x_reg == y_reg)
                            wb_val_next = 32'd0;
                        else if ($signed(x_reg) > $signed(y_reg))
                            wb_val_next = 32'd1;
                        else
                            wb_val_next = 32'hFFFF_FFFF;
                    end
                    OP_DIV:
                    begin
                        if (y_reg == 32'd0)
                        begin
                            status_next  = ST_DIV0;
                            stopped_next = 1'b1;
                            state_next   = S_RES;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_STR, OP_ISTR, OP_LDR, OP_ILDR:
                    begin
                        if (maddr_sel > WORD_LIM)
                        begin
                            status_next  = ST_BAD_ADR;
                            stopped_next = 1'b1;
                            state_next   = S_RES;
                        end
                        else
                        begin
                            last_next  = 2'd3;
                            sext_next  = 1'b0;
                            wb_en_next = (op5 == OP_LDR) || (op5 == OP_ILDR);
                            state_next = wb_en_next ? S_MEMR : S_MEMW;
                        end
                    end
                    OP_STB, OP_ISTB, OP_LDB, OP_ILDB:
                    begin
                        if (maddr_sel >= BYTE_END)
                        begin
                            status_next  = ST_BAD_ADR;
                            stopped_next = 1'b1;
                            state_next   = S_RES;
                        end
                        else
                        begin
                            last_next  = 2'd0;
                            sext_next  = 1'b1;
                            wb_en_next = (op5 == OP_LDB) || (op5 == OP_ILDB);
                            state_next = wb_en_next ? S_MEMR : S_MEMW;
                        end
                    end
                    OP_TRP:
                    begin
                        wb_en_next = 1'b0;
                        if (a_w == TRAP_HALT)
                            stopped_next = 1'b1;
                        else if (a_w == TRAP_OUT_INT)
                        begin
                            outv_next   = 1'b1;
                            outval_next = x_reg;
                        end
                        else if (a_w == TRAP_OUT_CHR)
                        begin
                            outv_next   = 1'b1;
                            outc_next   = 1'b1;
                            outval_next = {24'd0, x_reg[7:0]};
                        end
                        else if (a_w == TRAP_IN_CHR)
                        begin
                            wb_en_next  = 1'b1;
                            wb_idx_next = REG_IO;
                            wb_val_next = {24'd0, req_reg.input_char};
                        end
                        else if (a_w != TRAP_NOP)
                        begin
                            status_next = ST_BAD_TRP;
                            stopped_next = 1'b1;
                            state_next  = S_RES;
                        end
                    end
                    default:
                    begin
                        status_next  = ST_BAD_OP;
                        stopped_next = 1'b1;
                        state_next   = S_RES;
                    end
                endcase
            end
            S_MEMW:
            begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = AW'(maddr_reg + 32'(cnt_reg));
                mem_wdata = st_reg[7:0];
                st_next   = {8'd0, st_reg[31:8]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == last_reg)
                    state_next = S_WB;
            end
            S_MEMR:
            begin
                mem_en   = 1'b1;
                mem_addr = AW'(maddr_reg + 32'(cnt_reg));
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == last_reg)
                    state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                wb_val_next = sext_reg ? {{24{mem_rdata[7]}}, mem_rdata}
                                       : {mem_rdata, ld_reg[31:8]};
                state_next  = S_WB;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wb_val_next = div_q;
                    state_next  = S_WB;
                end
            end
            S_WB:
            begin
                // A write to PC lands before the advance
                if (wb_en_reg && wb_idx_reg == REG_PC)
                    pc_next = wb_val_reg + 32'd12;
                else
                begin
                    rf_we   = wb_en_reg;
                    pc_next = pc_reg + 32'd12;
                end
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.pc_after    = pc_reg[ADDR_W-1:0];
                    res_next.halted      = stopped_reg;
                    res_next.out_valid   = outv_reg;
                    res_next.out_is_char = outc_reg;
                    res_next.out_value   = outval_reg;
                    res_next.status      = status_reg;
                    res_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_pend_next = mem_en && !mem_we;
        rsel_pc_next = (rf_raddr == REG_PC);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            stopped_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            pc_reg        <= 32'd0;
            start_reg     <= '0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            stopped_reg   <= stopped_next;
            res_valid_reg <= res_valid_next;
            rd_pend_reg   <= rd_pend_next;
            pc_reg        <= pc_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START)
                    start_reg <= cfg_data;
                else if (cfg_index == CFG_LIMIT)
                    limit_reg <= cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        res_reg     <= res_next;
        instr_reg   <= instr_next;
        ld_reg      <= ld_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        wb_val_reg  <= wb_val_next;
        wb_idx_reg  <= wb_idx_next;
        wb_en_reg   <= wb_en_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
        maddr_reg   <= maddr_next;
        st_reg      <= st_next;
        sext_reg    <= sext_next;
        rsel_pc_reg <= rsel_pc_next;
        status_reg  <= status_next;
        outv_reg    <= outv_next;
        outc_reg    <= outc_next;
        outval_reg  <= outval_next;
    end

    `TBIS_ASSERT(a_halt_sticks, !$fell(stopped_reg), "machine left the halted state")
    `TBIS_ASSERT(a_start_sticks, !$fell(started_reg), "started flag dropped")
    `TBIS_ASSERT(a_res_from_res, $rose(res_valid_reg) |-> $past(state_reg == S_RES),
                 "result raised outside the result state")
    `TBIS_ASSERT(a_div_owned, div_busy |-> (state_reg == S_DIV),
                 "divider running while sequencer is elsewhere")
    `TBIS_ASSERT_ALWAYS(a_no_access_in_clear, mem_busy |-> !mem_en,
                        "memory access during clearing sweep")

endmodule
